// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the order book matcher.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("Assertion failed in the order book matcher.");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("Forbidden condition seen in the order book matcher.");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hdl/lobm_pkg.sv =====
// Types and constants of the limit order book matcher.
// No dependencies; used by the interfaces, the top level and lobm_engine.
package lobm_pkg;
   localparam int BOOK_DEPTH = 64;
   localparam int PRICE_BITS = 16;
   localparam int QTY_BITS = 16;
   localparam int IDX_W = $clog2(BOOK_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   typedef struct packed {
      logic [PRICE_BITS-1:0] price;
      logic [QTY_BITS-1:0]   qty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                  side;
      logic [QTY_BITS-1:0]   quantity;
      logic [PRICE_BITS-1:0] price;
      logic                  new_case;
   } order_type;

   typedef struct packed {
      logic                  ask_valid;
      logic [PRICE_BITS-1:0] ask_price;
      logic                  bid_valid;
      logic [PRICE_BITS-1:0] bid_price;
      logic                  trade_valid;
      logic [PRICE_BITS-1:0] last_trade_price;
      logic                  order_dropped;
   } result_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } eng_ctl_type;

   typedef struct packed {
      logic             idle;
      logic             done;
      logic [CNT_W-1:0] bid_cnt;
      logic [CNT_W-1:0] ask_cnt;
   } eng_stat_type;
endpackage

// ===== hdl/lobm_req_if.sv =====
// Order channel of the limit order book matcher.
// Depends on lobm_pkg for the order type.
interface lobm_req_if;
   logic                 valid;
   logic                 ready;
   lobm_pkg::order_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/lobm_rsp_if.sv =====
// Result channel of the limit order book matcher.
// Depends on lobm_pkg for the result type.
interface lobm_rsp_if;
   logic                  valid;
   logic                  ready;
   lobm_pkg::result_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/limit_order_book_matcher_core.sv =====
// Limit order book matcher, top level: order and result handshakes around the engine.
// Uses lobm_pkg, lobm_req_if, lobm_rsp_if, lobm_engine and assert_macros.svh.
//
// Each accepted order is written into its side's book in the cycle it is accepted,
// or dropped if that book is full. The engine then scans both book RAMs through
// their single read port, one entry per cycle, up to the larger book's entry count;
// ST_DECIDE then decides whether the best bid and best ask cross and rewrites a
// reduced entry on a partial fill. Each match then refills the removed slot with
// the book's last entry in ST_MOVE and starts a fresh scan. The next order
// is taken once the result has moved into the output register; the result may
// wait there while the following order is worked on.
`include "assert_macros.svh"

module limit_order_book_matcher_core (
   input logic        clock,
   input logic        reset,
   lobm_req_if.sink   req_ch,
   lobm_rsp_if.source rsp_ch
);
   lobm_pkg::eng_ctl_type  ctl;
   lobm_pkg::eng_stat_type stat;
   lobm_pkg::result_type   result;
   lobm_pkg::result_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   load;

   assign req_ch.ready = stat.idle;
   assign ctl.start    = req_ch.valid && stat.idle;
   assign ctl.out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load         = stat.done && ctl.out_free;

   lobm_engine u_engine (
      .clock(clock), .reset(reset), .ctl(ctl), .order(req_ch.payload),
      .stat(stat), .result(result)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   `ASSERT_NEVER(a_bid_cnt_range, clock, reset,
      stat.bid_cnt > lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH))
   `ASSERT_NEVER(a_ask_cnt_range, clock, reset,
      stat.ask_cnt > lobm_pkg::CNT_W'(lobm_pkg::BOOK_DEPTH))
   `ASSERT_PROP(a_busy_after_accept, clock, reset,
      (req_ch.valid && req_ch.ready) |=> !stat.idle)
   `ASSERT_NEVER(a_book_not_crossed, clock, reset,
      rsp_ch.valid && rsp_ch.payload.ask_valid && rsp_ch.payload.bid_valid &&
      (rsp_ch.payload.bid_price >= rsp_ch.payload.ask_price))
endmodule

// ===== hdl/lobm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lobm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/lobm_engine.sv =====
// Matching engine: inserts orders, scans both books for the best entries and
// executes matches by read-modify-write on the book RAMs. Uses lobm_pkg, lobm_ram.
module lobm_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  lobm_pkg::eng_ctl_type  ctl,
   input  lobm_pkg::order_type    order,
   output lobm_pkg::eng_stat_type stat,
   output lobm_pkg::result_type   result
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_MOVE, ST_RESULT
   } state_type;

   localparam int IW = lobm_pkg::IDX_W;
   localparam int CW = lobm_pkg::CNT_W;
   localparam int PW = lobm_pkg::PRICE_BITS;
   localparam int QW = lobm_pkg::QTY_BITS;

   state_type state_ff, state_in;
   logic [CW-1:0] bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   logic [PW-1:0] last_trade_ff, last_trade_in;
   logic trade_seen_ff, trade_seen_in, dropped_ff, dropped_in;
   logic [CW-1:0] scan_ptr_ff, scan_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic rd_live_ff, rd_live_in;
   logic [IW-1:0] bi_ff, bi_in, ai_ff, ai_in;
   lobm_pkg::entry_type bb_ff, bb_in, ba_ff, ba_in;
   logic rm_bid_ff, rm_bid_in, rm_ask_ff, rm_ask_in;

   logic bid_we, ask_we;
   logic [IW-1:0] bid_waddr, ask_waddr, bid_raddr, ask_raddr;
   lobm_pkg::entry_type bid_wdata, ask_wdata, bid_rd, ask_rd;

   logic [CW-1:0] bc, ac, scan_max;
   logic crossed;

   lobm_ram #(.DEPTH(lobm_pkg::BOOK_DEPTH), .WIDTH(lobm_pkg::ENTRY_W)) u_bid_ram (
      .clock(clock), .we(bid_we), .waddr(bid_waddr), .wdata(bid_wdata),
      .raddr(bid_raddr), .rdata(bid_rd)
   );

   lobm_ram #(.DEPTH(lobm_pkg::BOOK_DEPTH), .WIDTH(lobm_pkg::ENTRY_W)) u_ask_ram (
      .clock(clock), .we(ask_we), .waddr(ask_waddr), .wdata(ask_wdata),
      .raddr(ask_raddr), .rdata(ask_rd)
   );

   assign scan_max = (bid_cnt_ff > ask_cnt_ff) ? bid_cnt_ff : ask_cnt_ff;
   assign crossed = (bid_cnt_ff != '0) && (ask_cnt_ff != '0) && (bb_ff.price >= ba_ff.price);

   always_comb begin
      state_in      = state_ff;
      bid_cnt_in    = bid_cnt_ff;
      ask_cnt_in    = ask_cnt_ff;
      last_trade_in = last_trade_ff;
      trade_seen_in = trade_seen_ff;
      dropped_in    = dropped_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_live_in    = 1'b0;
      bi_in         = bi_ff;
      ai_in         = ai_ff;
      bb_in         = bb_ff;
      ba_in         = ba_ff;
      rm_bid_in     = rm_bid_ff;
      rm_ask_in     = rm_ask_ff;
      bid_we        = 1'b0;
      ask_we        = 1'b0;
      bid_waddr     = bi_ff;
      ask_waddr     = ai_ff;
      bid_wdata     = bid_rd;
      ask_wdata     = ask_rd;
      bid_raddr     = scan_ptr_ff[IW-1:0];
      ask_raddr     = scan_ptr_ff[IW-1:0];
      bc            = order.new_case ? '0 : bid_cnt_ff;
      ac            = order.new_case ? '0 : ask_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               if (order.new_case) begin
                  last_trade_in = '0;
                  trade_seen_in = 1'b0;
               end
               bid_cnt_in  = bc;
               ask_cnt_in  = ac;
               dropped_in  = 1'b0;
               scan_ptr_in = '0;
               state_in    = ST_SCAN;
               if (!order.side) begin
                  if (bc < CW'(lobm_pkg::BOOK_DEPTH)) begin
                     bid_we     = 1'b1;
                     bid_waddr  = bc[IW-1:0];
                     bid_wdata  = '{price: order.price, qty: order.quantity};
                     bid_cnt_in = bc + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else begin
                  if (ac < CW'(lobm_pkg::BOOK_DEPTH)) begin
                     ask_we     = 1'b1;
                     ask_waddr  = ac[IW-1:0];
                     ask_wdata  = '{price: order.price, qty: order.quantity};
                     ask_cnt_in = ac + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_ptr_ff < scan_max) begin
               rd_live_in  = 1'b1;
               rd_ptr_in   = scan_ptr_ff;
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end else if (!rd_live_ff) begin
               state_in = ST_DECIDE;
            end
            if (rd_live_ff && (rd_ptr_ff < bid_cnt_ff)) begin
               if ((rd_ptr_ff == '0) || (bid_rd.price > bb_ff.price) ||
                   ((bid_rd.price == bb_ff.price) && (bid_rd.qty > bb_ff.qty))) begin
                  bb_in = bid_rd;
                  bi_in = rd_ptr_ff[IW-1:0];
               end
            end
            if (rd_live_ff && (rd_ptr_ff < ask_cnt_ff)) begin
               if ((rd_ptr_ff == '0) || (ask_rd.price < ba_ff.price) ||
                   ((ask_rd.price == ba_ff.price) && (ask_rd.qty < ba_ff.qty))) begin
                  ba_in = ask_rd;
                  ai_in = rd_ptr_ff[IW-1:0];
               end
            end
         end
         ST_DECIDE: begin
            rm_bid_in = 1'b0;
            rm_ask_in = 1'b0;
            if (crossed) begin
               last_trade_in = ba_ff.price;
               trade_seen_in = 1'b1;
               state_in      = ST_MOVE;
               if (bb_ff.qty == ba_ff.qty) begin
                  rm_bid_in = 1'b1;
                  rm_ask_in = 1'b1;
               end else if (bb_ff.qty > ba_ff.qty) begin
                  rm_ask_in = 1'b1;
                  bid_we    = 1'b1;
                  bid_wdata = '{price: bb_ff.price, qty: QW'(bb_ff.qty - ba_ff.qty)};
               end else begin
                  rm_bid_in = 1'b1;
                  ask_we    = 1'b1;
                  ask_wdata = '{price: ba_ff.price, qty: QW'(ba_ff.qty - bb_ff.qty)};
               end
               if (rm_bid_in) begin
                  bid_cnt_in = bid_cnt_ff - 1'b1;
                  bid_raddr  = bid_cnt_in[IW-1:0];
               end
               if (rm_ask_in) begin
                  ask_cnt_in = ask_cnt_ff - 1'b1;
                  ask_raddr  = ask_cnt_in[IW-1:0];
               end
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_MOVE: begin
            bid_we      = rm_bid_ff;
            ask_we      = rm_ask_ff;
            scan_ptr_in = '0;
            state_in    = ST_SCAN;
         end
         ST_RESULT: begin
            if (ctl.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bid_cnt_ff    <= '0;
         ask_cnt_ff    <= '0;
         last_trade_ff <= '0;
         trade_seen_ff <= 1'b0;
         rd_live_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bid_cnt_ff    <= bid_cnt_in;
         ask_cnt_ff    <= ask_cnt_in;
         last_trade_ff <= last_trade_in;
         trade_seen_ff <= trade_seen_in;
         rd_live_ff    <= rd_live_in;
      end
      dropped_ff  <= dropped_in;
      scan_ptr_ff <= scan_ptr_in;
      rd_ptr_ff   <= rd_ptr_in;
      bi_ff       <= bi_in;
      ai_ff       <= ai_in;
      bb_ff       <= bb_in;
      ba_ff       <= ba_in;
      rm_bid_ff   <= rm_bid_in;
      rm_ask_ff   <= rm_ask_in;
   end

   assign stat.idle    = (state_ff == ST_IDLE);
   assign stat.done    = (state_ff == ST_RESULT);
   assign stat.bid_cnt = bid_cnt_ff;
   assign stat.ask_cnt = ask_cnt_ff;

   assign result.ask_valid        = (ask_cnt_ff != '0);
   assign result.ask_price        = (ask_cnt_ff != '0) ? ba_ff.price : '0;
   assign result.bid_valid        = (bid_cnt_ff != '0);
   assign result.bid_price        = (bid_cnt_ff != '0) ? bb_ff.price : '0;
   assign result.trade_valid      = trade_seen_ff;
   assign result.last_trade_price = trade_seen_ff ? last_trade_ff : '0;
   assign result.order_dropped    = dropped_ff;
endmodule
